/* hw/rtl/point_in_convex_polygon_unit_defines.svh */
// ----------------------------------------------------------------------------
// point_in_convex_polygon_unit_defines
// Assertion macros used by the checker file of the polygon test unit.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_CONVEX_POLYGON_UNIT_DEFINES_SVH
`define POINT_IN_CONVEX_POLYGON_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define PCP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcp check failed");

// next-cycle implication, disabled while reset is high
`define PCP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcp check failed");

`endif

/* hw/rtl/pcp_pkg.sv */
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared constants, request and status codes, and control structs of the
// point in convex polygon unit.
// ----------------------------------------------------------------------------
package pcp_pkg;

   // defaults of the top level parameters
   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_BITS_DEF   = 16;

   // a query needs at least a triangle
   localparam int MIN_VERTICES = 3;

   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FEW  = 2'd2;

   // commands to the shared cross product unit
   typedef struct packed {
      logic load_p;
      logic load_q;
   } pcp_mul_cmd_type;

   // sign of the finished cross product
   typedef struct packed {
      logic pos;
      logic neg;
   } pcp_sign_type;

endpackage

/* hw/rtl/pcp_vertex_ram.sv */
// ----------------------------------------------------------------------------
// pcp_vertex_ram
// Vertex store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcp_vertex_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hw/rtl/pcp_cross_unit.sv */
// ----------------------------------------------------------------------------
// pcp_cross_unit
// Shared multiplier that builds both partial products of one cross product,
// one after the other, and gives the sign of their difference.
// ----------------------------------------------------------------------------
module pcp_cross_unit #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  pcp_pkg::pcp_mul_cmd_type      cmd,
   input  logic signed [COORD_BITS:0]    op_a,
   input  logic signed [COORD_BITS:0]    op_b,
   output pcp_pkg::pcp_sign_type         sign
);
   import pcp_pkg::*;

   localparam int PROD_W = 2 * (COORD_BITS + 1);

   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] p_ff;
   logic signed [PROD_W-1:0] q_ff;
   logic        [PROD_W:0]   diff;

   // one exact signed multiply per cycle
   assign prod = op_a * op_b;

   // capture first and second partial products
   always_ff @(posedge clock) begin
      if (cmd.load_p) begin
         p_ff <= prod;
      end
      if (cmd.load_q) begin
         q_ff <= prod;
      end
   end

   // sign of p - q, one bit wider so it cannot overflow
   assign diff     = {p_ff[PROD_W-1], p_ff} - {q_ff[PROD_W-1], q_ff};
   assign sign.neg = diff[PROD_W];
   assign sign.pos = !diff[PROD_W] && (diff != '0);

endmodule

/* hw/rtl/point_in_convex_polygon_unit.sv */
// ----------------------------------------------------------------------------
// point_in_convex_polygon_unit
// Vertex list with a cross product sign test for point queries.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken at a rising edge with start high and busy low.
//   req_type selects clear, append of (req_x_coord, req_y_coord), or a
//   query of that point. Every request gives exactly one result beat:
//   rsp_strobe is high for one cycle with inside, status and vertex total.
//   Clear, append, unused codes and queries on fewer than three vertices
//   answer in the cycle after the request and leave busy low, so such
//   beats may be issued every cycle.
//   A query on n vertices walks every edge, the closing one last; each
//   vertex takes one read of the single vertex memory port and each edge
//   two passes through the shared multiplier. busy stays high during the
//   walk, which ends early when the point is found outside, and is low
//   again when the result beat is shown.
//   Reset empties the vertex list; the memory itself is not cleared, only
//   entries below the vertex count are ever read.
//   The receiver cannot stall: each result beat is shown for one cycle.
// ----------------------------------------------------------------------------
module point_in_convex_polygon_unit #(
   parameter int MAX_VERTICES = pcp_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = pcp_pkg::COORD_BITS_DEF,
   localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [pcp_pkg::REQ_W-1:0]    req_type,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   output logic                         rsp_strobe,
   output logic                         rsp_inside_res,
   output logic [pcp_pkg::STATUS_W-1:0] rsp_status,
   output logic [CNT_W-1:0]             rsp_vertex_total
);
   import pcp_pkg::*;

   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int VERT_W = 2 * COORD_BITS;
   localparam int OP_W   = COORD_BITS + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CAPTURE,
      S_DIFF,
      S_MUL_P,
      S_MUL_Q,
      S_EVAL,
      S_CLOSE
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_last;
   logic [ADDR_W-1:0]        idx_ff;
   logic                     first_ff;
   logic                     closing_ff;
   logic                     ref_valid_ff;
   logic                     ref_pos_ff;
   logic [COORD_BITS-1:0]    px_ff;
   logic [COORD_BITS-1:0]    py_ff;
   logic [VERT_W-1:0]        prev_ff;
   logic [VERT_W-1:0]        cur_ff;
   logic [VERT_W-1:0]        first_v_ff;
   logic signed [OP_W-1:0]   dx_ff;
   logic signed [OP_W-1:0]   dy_ff;
   logic signed [OP_W-1:0]   ayp_ff;
   logic signed [OP_W-1:0]   axp_ff;
   logic                     rsp_strobe_ff;
   logic                     rsp_inside_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [CNT_W-1:0]         rsp_total_ff;

   logic                     accept;
   logic                     full;
   logic                     wr_en;
   logic                     rd_en;
   logic [VERT_W-1:0]        rd_data;
   logic [COORD_BITS-1:0]    ax;
   logic [COORD_BITS-1:0]    ay;
   logic [COORD_BITS-1:0]    bx;
   logic [COORD_BITS-1:0]    by;
   logic signed [OP_W-1:0]   dx_in;
   logic signed [OP_W-1:0]   dy_in;
   logic signed [OP_W-1:0]   ayp_in;
   logic signed [OP_W-1:0]   axp_in;
   logic signed [OP_W-1:0]   mul_a;
   logic signed [OP_W-1:0]   mul_b;
   pcp_mul_cmd_type          mul_cmd;
   pcp_sign_type             sign;
   logic                     outside;

   // handshake and store control
   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && (state_ff == S_IDLE);
   assign full       = (count_ff >= CNT_W'(MAX_VERTICES));
   assign wr_en      = accept && (req_type == REQ_APPEND) && !full;
   assign rd_en      = (state_ff == S_READ);
   assign count_last = count_ff - CNT_W'(1);

   pcp_vertex_ram #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (VERT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_y_coord, req_x_coord}),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // edge from a (previous vertex) to b (current vertex)
   assign ax = prev_ff[COORD_BITS-1:0];
   assign ay = prev_ff[VERT_W-1:COORD_BITS];
   assign bx = cur_ff[COORD_BITS-1:0];
   assign by = cur_ff[VERT_W-1:COORD_BITS];

   // operand differences, one bit wider than the coordinates
   assign dx_in  = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
   assign dy_in  = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
   assign ayp_in = {ay[COORD_BITS-1], ay} - {py_ff[COORD_BITS-1], py_ff};
   assign axp_in = {ax[COORD_BITS-1], ax} - {px_ff[COORD_BITS-1], px_ff};

   // multiplier operand select: dx*(ay-py) first, then dy*(ax-px)
   assign mul_cmd.load_p = (state_ff == S_MUL_P);
   assign mul_cmd.load_q = (state_ff == S_MUL_Q);
   assign mul_a = mul_cmd.load_p ? dx_ff  : dy_ff;
   assign mul_b = mul_cmd.load_p ? ayp_ff : axp_ff;

   pcp_cross_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_cross (
      .clock (clock),
      .cmd   (mul_cmd),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .sign  (sign)
   );

   // strictly opposite sign to the first edge
   assign outside = ref_valid_ff && (ref_pos_ff ? sign.neg : sign.pos);

   // sequencer, list count and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_inside_ff <= 1'b0;
                  rsp_status_ff <= ST_OK;
                  rsp_total_ff  <= count_ff;
                  unique case (req_type)
                     REQ_CLEAR: begin
                        count_ff      <= '0;
                        rsp_total_ff  <= '0;
                        rsp_strobe_ff <= 1'b1;
                     end
                     REQ_APPEND: begin
                        if (full) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           count_ff     <= count_ff + CNT_W'(1);
                           rsp_total_ff <= count_ff + CNT_W'(1);
                        end
                        rsp_strobe_ff <= 1'b1;
                     end
                     REQ_QUERY: begin
                        if (count_ff < CNT_W'(MIN_VERTICES)) begin
                           rsp_status_ff <= ST_FEW;
                           rsp_strobe_ff <= 1'b1;
                        end else begin
                           px_ff        <= req_x_coord;
                           py_ff        <= req_y_coord;
                           idx_ff       <= count_last[ADDR_W-1:0];
                           first_ff     <= 1'b1;
                           closing_ff   <= 1'b0;
                           ref_valid_ff <= 1'b0;
                           state_ff     <= S_READ;
                        end
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_READ: begin
               state_ff <= S_CAPTURE;
            end
            S_CAPTURE: begin
               prev_ff <= cur_ff;
               cur_ff  <= rd_data;
               if (first_ff) begin
                  first_ff   <= 1'b0;
                  first_v_ff <= rd_data;
                  idx_ff     <= idx_ff - ADDR_W'(1);
                  state_ff   <= S_READ;
               end else begin
                  state_ff <= S_DIFF;
               end
            end
            S_CLOSE: begin
               prev_ff    <= cur_ff;
               cur_ff     <= first_v_ff;
               closing_ff <= 1'b1;
               state_ff   <= S_DIFF;
            end
            S_DIFF: begin
               dx_ff    <= dx_in;
               dy_ff    <= dy_in;
               ayp_ff   <= ayp_in;
               axp_ff   <= axp_in;
               state_ff <= S_MUL_P;
            end
            S_MUL_P: begin
               state_ff <= S_MUL_Q;
            end
            S_MUL_Q: begin
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               if (!ref_valid_ff) begin
                  ref_valid_ff <= 1'b1;
                  ref_pos_ff   <= sign.pos;
               end
               priority if (outside) begin
                  rsp_inside_ff <= 1'b0;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end else if (closing_ff) begin
                  rsp_inside_ff <= 1'b1;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end else if (idx_ff == '0) begin
                  state_ff <= S_CLOSE;
               end else begin
                  idx_ff   <= idx_ff - ADDR_W'(1);
                  state_ff <= S_READ;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // result ports
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_inside_res   = rsp_inside_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_vertex_total = rsp_total_ff;

endmodule

/* hw/rtl/pcp_checker.sv */
// ----------------------------------------------------------------------------
// pcp_checker
// Port level checks of the polygon test unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_in_convex_polygon_unit_defines.svh"

module pcp_checker #(
   parameter int MAX_VERTICES = pcp_pkg::MAX_VERTICES_DEF,
   localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [pcp_pkg::REQ_W-1:0]    req_type,
   input  logic                         rsp_strobe,
   input  logic                         rsp_inside_res,
   input  logic [pcp_pkg::STATUS_W-1:0] rsp_status,
   input  logic [CNT_W-1:0]             rsp_vertex_total
);
   import pcp_pkg::*;

   // any beat that is not a query answers in the next cycle
   `PCP_ASSERT_NXT(a_quick_rsp, clock, reset, start && !busy && (req_type != REQ_QUERY), rsp_strobe)

   // no result beat while a query walk is running
   `PCP_ASSERT_IMP(a_quiet_busy, clock, reset, busy, !rsp_strobe)

   // a dropped append reports a full store
   `PCP_ASSERT_IMP(a_full_total, clock, reset, rsp_strobe && (rsp_status == ST_FULL), rsp_vertex_total == CNT_W'(MAX_VERTICES))

   // too few vertices never gives an inside answer
   `PCP_ASSERT_IMP(a_few_outside, clock, reset, rsp_strobe && (rsp_status == ST_FEW), !rsp_inside_res)

endmodule

bind point_in_convex_polygon_unit pcp_checker #(
   .MAX_VERTICES (MAX_VERTICES)
) u_pcp_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_type         (req_type),
   .rsp_strobe       (rsp_strobe),
   .rsp_inside_res   (rsp_inside_res),
   .rsp_status       (rsp_status),
   .rsp_vertex_total (rsp_vertex_total)
);
